@@ rtl/detection_box_decode_core_assert.svh @@
// Assertion macros shared by the core; clk and rst_n come from the using scope.
`ifndef DETECTION_BOX_DECODE_CORE_ASSERT_SVH
`define DETECTION_BOX_DECODE_CORE_ASSERT_SVH

// Same-cycle implication.
`define DBD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication.
`define DBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/dbd_pkg.sv @@
package dbd_pkg;

    localparam int CLASS_COUNT_DEF = 80;
    localparam int JOB_DEPTH_DEF   = 4;
    localparam int RES_DEPTH_DEF   = 2;

    localparam int CLASS_W    = 7;
    localparam int SCORE_W    = 16;
    localparam int COORD_W    = 16;
    localparam int PIX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int RATIO_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CLASS_W-1:0] CNT_MAX = '1;

    // corner arithmetic
    localparam int NUM_W       = 20;
    localparam int MAG_W       = 18;
    localparam int FRAC_SHIFT  = 11;
    localparam int DIVD_W      = MAG_W + FRAC_SHIFT;
    localparam int ROUND_SHIFT = 6;
    localparam int QC_W        = PIX_W + ROUND_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_CLASS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_X           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_Y           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_RATIO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd6;

    localparam logic [CLASS_W-1:0] RST_TARGET_CLASS    = 7'd67;
    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd16384;
    localparam logic [COORD_W-1:0] RST_PAD             = 16'd0;
    localparam logic [RATIO_W-1:0] RST_SCALE_RATIO     = 16'd4096;
    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH     = 13'd640;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT    = 13'd480;

    typedef struct packed {
        logic [CLASS_W-1:0] target_class;
        logic [SCORE_W-1:0] score_threshold;
        logic [COORD_W-1:0] pad_x;
        logic [COORD_W-1:0] pad_y;
        logic [RATIO_W-1:0] scale_ratio;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
        logic [SCORE_W-1:0] confidence;
    } job_t;

    typedef struct packed {
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   span_x;
        logic [PIX_W-1:0]   span_y;
        logic [SCORE_W-1:0] confidence;
    } result_t;

endpackage

@@ rtl/dbd_fifo.sv @@
module dbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = data_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/dbd_front.sv @@
module dbd_front #(
    parameter int CLASS_COUNT = dbd_pkg::CLASS_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [dbd_pkg::SCORE_W-1:0]  class_score,
    input  logic [dbd_pkg::COORD_W-1:0]  center_x,
    input  logic [dbd_pkg::COORD_W-1:0]  center_y,
    input  logic [dbd_pkg::COORD_W-1:0]  box_width,
    input  logic [dbd_pkg::COORD_W-1:0]  box_height,
    input  logic                         last_class,
    input  dbd_pkg::cfg_t                cfg,
    output logic                         job_push,
    output dbd_pkg::job_t                job
);

    localparam int CMP_W = dbd_pkg::CLASS_W + 1;
    localparam logic [CMP_W-1:0] CLASS_LIMIT = CMP_W'(CLASS_COUNT);

    logic [dbd_pkg::CLASS_W-1:0] cnt_reg, cnt_next;
    logic [dbd_pkg::SCORE_W-1:0] best_reg, best_next;
    logic [dbd_pkg::CLASS_W-1:0] cls_reg, cls_next;
    logic [dbd_pkg::COORD_W-1:0] cx_reg, cy_reg, w_reg, h_reg;

    logic                        first;
    logic                        in_range;
    logic [dbd_pkg::SCORE_W-1:0] new_best;
    logic [dbd_pkg::CLASS_W-1:0] new_cls;

    always_comb
    begin
        first    = (cnt_reg == '0);
        in_range = ({1'b0, cnt_reg} < CLASS_LIMIT);
        new_best = best_reg;
        new_cls  = cls_reg;
        if (first)
        begin
            new_best = class_score;
            new_cls  = '0;
        end
        else if (in_range && (class_score > best_reg))
        begin
            new_best = class_score;
            new_cls  = cnt_reg;
        end

        job.center_x   = first ? center_x : cx_reg;
        job.center_y   = first ? center_y : cy_reg;
        job.box_width  = first ? box_width : w_reg;
        job.box_height = first ? box_height : h_reg;
        job.confidence = new_best;

        job_push = accept && last_class && (new_cls == cfg.target_class)
                   && (new_best >= cfg.score_threshold);

        // the last score closes the detection and clears the search
        if (last_class)
        begin
            cnt_next  = '0;
            best_next = '0;
            cls_next  = '0;
        end
        else
        begin
            cnt_next  = (cnt_reg == dbd_pkg::CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
            best_next = new_best;
            cls_next  = new_cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            best_reg <= '0;
            cls_reg  <= '0;
        end
        else if (accept)
        begin
            cnt_reg  <= cnt_next;
            best_reg <= best_next;
            cls_reg  <= cls_next;
        end
    end

    // latch the box on the first score of a detection
    always_ff @(posedge clk)
    begin
        if (accept && first)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            w_reg  <= box_width;
            h_reg  <= box_height;
        end
    end

endmodule

@@ rtl/dbd_div.sv @@
module dbd_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dbd_pkg::DIVD_W-1:0]   dividend,
    input  logic [dbd_pkg::RATIO_W-1:0]  divisor,
    output logic                         done,
    output logic [dbd_pkg::DIVD_W-1:0]   quotient
);

    localparam int W     = dbd_pkg::DIVD_W;
    localparam int R     = dbd_pkg::RATIO_W;
    localparam int CNT_W = $clog2(W + 1);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(W);

    logic [W-1:0]     dq_reg;
    logic [R-1:0]     rem_reg;
    logic [R-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [R:0] shifted;
    logic [R:0] diff;
    logic       fits;

    assign shifted  = {rem_reg, dq_reg[W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign fits     = (shifted >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = dq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_START;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // restoring division, one quotient bit per cycle; quotient shifts in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            dq_reg  <= {dq_reg[W-2:0], fits};
            rem_reg <= fits ? diff[R-1:0] : shifted[R-1:0];
        end
    end

endmodule

@@ rtl/dbd_back.sv @@
module dbd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dbd_pkg::cfg_t     cfg,
    input  logic              job_empty,
    input  dbd_pkg::job_t     job,
    output logic              job_pop,
    input  logic              res_full,
    output logic              res_push,
    output dbd_pkg::result_t  res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [1:0] CORNER_X1 = 2'd0;
    localparam logic [1:0] CORNER_Y1 = 2'd1;
    localparam logic [1:0] CORNER_X2 = 2'd2;
    localparam logic [1:0] CORNER_Y2 = 2'd3;

    localparam int NUM_W = dbd_pkg::NUM_W;
    localparam int CW    = dbd_pkg::COORD_W;
    localparam int PW    = dbd_pkg::PIX_W;
    localparam int QW    = dbd_pkg::QC_W;
    localparam int RS    = dbd_pkg::ROUND_SHIFT;
    localparam logic [QW-1:0] ROUND_HALF = QW'(1) << (RS - 1);

    logic [1:0]     state_reg, state_next;
    logic [1:0]     corner_reg, corner_next;
    dbd_pkg::job_t  job_reg;
    logic [PW-1:0]  px_reg [4];

    logic [CW-1:0]             sel_c, sel_s, sel_pad;
    logic [dbd_pkg::DIM_W-1:0] sel_dim;
    logic                      sel_plus;
    logic signed [NUM_W-1:0]   twice_c, size_v, twice_pad, num;
    logic                      num_pos;

    logic                          div_start, div_done;
    logic [dbd_pkg::DIVD_W-1:0]    dividend, quotient;
    logic [dbd_pkg::RATIO_W-1:0]   divisor;

    logic [dbd_pkg::DIM_W-1:0] lim_full;
    logic [PW-1:0]             lim;
    logic [QW-1:0]             lim64, qc, qsum;
    logic [PW-1:0]             pix;
    logic                      store_px;
    logic [PW-1:0]             px_value;
    logic                      nonempty;

    always_comb
    begin
        case (corner_reg)
            CORNER_X1:
            begin
                sel_c = job_reg.center_x; sel_s = job_reg.box_width;
                sel_pad = cfg.pad_x; sel_dim = cfg.frame_width; sel_plus = 1'b0;
            end
            CORNER_Y1:
            begin
                sel_c = job_reg.center_y; sel_s = job_reg.box_height;
                sel_pad = cfg.pad_y; sel_dim = cfg.frame_height; sel_plus = 1'b0;
            end
            CORNER_X2:
            begin
                sel_c = job_reg.center_x; sel_s = job_reg.box_width;
                sel_pad = cfg.pad_x; sel_dim = cfg.frame_width; sel_plus = 1'b1;
            end
            CORNER_Y2:
            begin
                sel_c = job_reg.center_y; sel_s = job_reg.box_height;
                sel_pad = cfg.pad_y; sel_dim = cfg.frame_height; sel_plus = 1'b1;
            end
            default:
            begin
                sel_c = job_reg.center_x; sel_s = job_reg.box_width;
                sel_pad = cfg.pad_x; sel_dim = cfg.frame_width; sel_plus = 1'b0;
            end
        endcase

        twice_c   = {{(NUM_W - CW - 1){1'b0}}, sel_c, 1'b0};
        size_v    = {{(NUM_W - CW){1'b0}}, sel_s};
        twice_pad = {{(NUM_W - CW - 1){1'b0}}, sel_pad, 1'b0};
        num       = sel_plus ? (twice_c + size_v - twice_pad) : (twice_c - size_v - twice_pad);
        // a corner at or left of zero clamps to zero without dividing
        num_pos   = !num[NUM_W-1] && (num != '0);

        dividend = {num[dbd_pkg::MAG_W-1:0], {dbd_pkg::FRAC_SHIFT{1'b0}}};
        divisor  = (cfg.scale_ratio == '0) ? dbd_pkg::RATIO_W'(1) : cfg.scale_ratio;

        lim_full = (sel_dim == '0) ? '0 : sel_dim - 1'b1;
        lim      = (lim_full > dbd_pkg::DIM_W'({PW{1'b1}})) ? {PW{1'b1}} : lim_full[PW-1:0];
        lim64    = {lim, {RS{1'b0}}};
        qc       = (quotient > dbd_pkg::DIVD_W'(lim64)) ? lim64 : quotient[QW-1:0];
        qsum     = qc + ROUND_HALF;
        pix      = qsum[RS +: PW];

        nonempty = (px_reg[CORNER_X2] > px_reg[CORNER_X1])
                   && (px_reg[CORNER_Y2] > px_reg[CORNER_Y1]);
        res.left       = px_reg[CORNER_X1];
        res.top        = px_reg[CORNER_Y1];
        res.span_x     = px_reg[CORNER_X2] - px_reg[CORNER_X1];
        res.span_y     = px_reg[CORNER_Y2] - px_reg[CORNER_Y1];
        res.confidence = job_reg.confidence;

        job_pop     = 1'b0;
        res_push    = 1'b0;
        div_start   = 1'b0;
        store_px    = 1'b0;
        px_value    = '0;
        state_next  = state_reg;
        corner_next = corner_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop     = 1'b1;
                    corner_next = CORNER_X1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (num_pos)
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    store_px = 1'b1;
                    px_value = '0;
                end
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    store_px = 1'b1;
                    px_value = pix;
                end
            end
            ST_EMIT:
            begin
                // drop an empty box, otherwise hold until the result queue has room
                if (!nonempty)
                begin
                    state_next = ST_IDLE;
                end
                else if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (store_px)
        begin
            if (corner_reg == CORNER_Y2)
            begin
                state_next = ST_EMIT;
            end
            else
            begin
                corner_next = corner_reg + 1'b1;
                state_next  = ST_SETUP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= CORNER_X1;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (store_px)
        begin
            px_reg[corner_reg] <= px_value;
        end
    end

    dbd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

endmodule

@@ rtl/detection_box_decode_core.sv @@
// Class scores are taken one per cycle while full is low; the score search adds no register,
// so a job is pushed as its last score is taken. A passing detection is decoded by one shared
// bit-serial divider, four corners in turn (a corner that clamps to zero skips the divider).
// The back end decodes one box at a time; full rises once the job queue holds JOB_DEPTH.
// Reset is asynchronous, active low: registers return to their defaults, queues empty,
// the score search clears.
`include "detection_box_decode_core_assert.svh"

module detection_box_decode_core #(
    parameter int CLASS_COUNT = dbd_pkg::CLASS_COUNT_DEF,
    parameter int JOB_DEPTH   = dbd_pkg::JOB_DEPTH_DEF,
    parameter int RES_DEPTH   = dbd_pkg::RES_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [dbd_pkg::SCORE_W-1:0]     class_score,
    input  logic [dbd_pkg::COORD_W-1:0]     center_x,
    input  logic [dbd_pkg::COORD_W-1:0]     center_y,
    input  logic [dbd_pkg::COORD_W-1:0]     box_width,
    input  logic [dbd_pkg::COORD_W-1:0]     box_height,
    input  logic                            last_class,
    output logic                            empty,
    input  logic                            pop,
    output logic [dbd_pkg::PIX_W-1:0]       left,
    output logic [dbd_pkg::PIX_W-1:0]       top,
    output logic [dbd_pkg::PIX_W-1:0]       span_x,
    output logic [dbd_pkg::PIX_W-1:0]       span_y,
    output logic [dbd_pkg::SCORE_W-1:0]     confidence,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dbd_pkg::cfg_t    cfg_reg;
    logic             accept;
    logic             job_push, job_pop, job_full, job_empty;
    dbd_pkg::job_t    job_in, job_head;
    logic             res_push, res_full;
    dbd_pkg::result_t res_item, res_head;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign full      = job_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_class    <= dbd_pkg::RST_TARGET_CLASS;
            cfg_reg.score_threshold <= dbd_pkg::RST_SCORE_THRESHOLD;
            cfg_reg.pad_x           <= dbd_pkg::RST_PAD;
            cfg_reg.pad_y           <= dbd_pkg::RST_PAD;
            cfg_reg.scale_ratio     <= dbd_pkg::RST_SCALE_RATIO;
            cfg_reg.frame_width     <= dbd_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height    <= dbd_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dbd_pkg::REG_TARGET_CLASS:
                    cfg_reg.target_class <= cfg_data[dbd_pkg::CLASS_W-1:0];
                dbd_pkg::REG_SCORE_THRESHOLD:
                    cfg_reg.score_threshold <= cfg_data[dbd_pkg::SCORE_W-1:0];
                dbd_pkg::REG_PAD_X:
                    cfg_reg.pad_x <= cfg_data[dbd_pkg::COORD_W-1:0];
                dbd_pkg::REG_PAD_Y:
                    cfg_reg.pad_y <= cfg_data[dbd_pkg::COORD_W-1:0];
                dbd_pkg::REG_SCALE_RATIO:
                    cfg_reg.scale_ratio <= cfg_data[dbd_pkg::RATIO_W-1:0];
                dbd_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= cfg_data[dbd_pkg::DIM_W-1:0];
                dbd_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[dbd_pkg::DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    dbd_front #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .class_score (class_score),
        .center_x    (center_x),
        .center_y    (center_y),
        .box_width   (box_width),
        .box_height  (box_height),
        .last_class  (last_class),
        .cfg         (cfg_reg),
        .job_push    (job_push),
        .job         (job_in)
    );

    dbd_fifo #(
        .WIDTH ($bits(dbd_pkg::job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .full    (job_full),
        .empty   (job_empty)
    );

    dbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_item)
    );

    dbd_fifo #(
        .WIDTH ($bits(dbd_pkg::result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_item),
        .rd_en   (pop),
        .rd_data (res_head),
        .full    (res_full),
        .empty   (empty)
    );

    assign left       = res_head.left;
    assign top        = res_head.top;
    assign span_x     = res_head.span_x;
    assign span_y     = res_head.span_y;
    assign confidence = res_head.confidence;

    `DBD_ASSERT_IMPL(a_job_room, job_push, !job_full)
    `DBD_ASSERT_IMPL(a_res_room, res_push, !res_full)
    `DBD_ASSERT_IMPL(a_res_nonempty, res_push, res_item.span_x != '0 && res_item.span_y != '0)
    `DBD_ASSERT_NEXT(a_job_visible, job_push, !job_empty)

endmodule
